// File: rtl/core/ssq_pkg.sv
`default_nettype none

package ssq_pkg;

	typedef enum logic [1:0] {
		ST_WAIT     = 2'd0,
		ST_STABLE   = 2'd1,
		ST_UNSTABLE = 2'd2,
		ST_NO_PROBE = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] range_low;
		logic [15:0] range_high;
		logic [15:0] stable_spread;
		logic [3:0]  fault_run_limit;
		logic [9:0]  sample_limit;
	} cfg_t;

	localparam logic [2:0] REG_RANGE_LOW     = 3'd0;
	localparam logic [2:0] REG_RANGE_HIGH    = 3'd1;
	localparam logic [2:0] REG_STABLE_SPREAD = 3'd2;
	localparam logic [2:0] REG_FAULT_LIMIT   = 3'd3;
	localparam logic [2:0] REG_SAMPLE_LIMIT  = 3'd4;

	localparam logic [15:0] RANGE_LOW_RST     = 16'd4267;
	localparam logic [15:0] RANGE_HIGH_RST    = 16'd22933;
	localparam logic [15:0] STABLE_SPREAD_RST = 16'd16;
	localparam logic [3:0]  FAULT_LIMIT_RST   = 4'd5;
	localparam logic [9:0]  SAMPLE_LIMIT_RST  = 10'd50;

	localparam logic [3:0] FAULT_RUN_MAX = 4'd15;
	localparam logic [9:0] TAKEN_MAX     = 10'd1023;

endpackage

`default_nettype wire

// File: rtl/core/sensor_stability_qualifier_unit.sv
`default_nettype none

// Probe stability qualifier.
// Input channel (in_valid/in_ready) carries one averaged converter code and a
// restart flag per beat; the output channel (out_valid/out_ready) returns one
// status and level per input beat, in order.
// Three register stages: input register, tracking stage (window, counters,
// decision) and result register. A beat passes through them in that order
// and waits in place while the next stage is full.
// Throughput is one beat per clock while out_ready is high; the window min,
// max and sum and the decision all settle in the tracking stage, and the divide
// by the depth sits between the tracking register and the result register.
// When out_ready is low the stages fill up one by one; in_ready falls only
// once all three hold a beat, and no beat is dropped or repeated.
// The config port (cfg_we, cfg_index, cfg_data) writes one register per clock
// and should only be used when the block is empty.
// Reset clears all stages, counters and the held decision and loads the
// default range, spread and limits. No clearing pass is needed.
module sensor_stability_qualifier_unit #(
	parameter int WINDOW_DEPTH = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] sample,
	input  wire logic               restart,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [15:0]      level
);
	import ssq_pkg::*;

	localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH);

	cfg_t cfg_q;

	logic               valid_s1;
	logic signed [15:0] sample_s1;
	logic               restart_s1;

	logic               valid_s2;
	status_t            status_s2;
	logic               mean_s2;
	logic signed [SUM_W-1:0] value_s2;

	logic               out_valid_q;
	status_t            status_q;
	logic signed [15:0] level_q;

	logic out_load, s2_free, s1_free, s1_go, s2_go;
	status_t                 trk_status;
	logic                    trk_mean;
	logic signed [SUM_W-1:0] trk_value;
	logic signed [15:0]      mean_level;

	assign out_load = !out_valid_q || out_ready;
	assign s2_go    = valid_s2 && out_load;
	assign s2_free  = !valid_s2 || out_load;
	assign s1_go    = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low       <= RANGE_LOW_RST;
			cfg_q.range_high      <= RANGE_HIGH_RST;
			cfg_q.stable_spread   <= STABLE_SPREAD_RST;
			cfg_q.fault_run_limit <= FAULT_LIMIT_RST;
			cfg_q.sample_limit    <= SAMPLE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW:     cfg_q.range_low       <= cfg_data;
				REG_RANGE_HIGH:    cfg_q.range_high      <= cfg_data;
				REG_STABLE_SPREAD: cfg_q.stable_spread   <= cfg_data;
				REG_FAULT_LIMIT:   cfg_q.fault_run_limit <= cfg_data[3:0];
				REG_SAMPLE_LIMIT:  cfg_q.sample_limit    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	ssq_track #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.sample  (sample_s1),
		.restart (restart_s1),
		.advance (s1_go),
		.status  (trk_status),
		.is_mean (trk_mean),
		.value   (trk_value)
	);

	ssq_mean #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_mean (
		.is_mean (mean_s2),
		.value   (value_s2),
		.level   (mean_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_load) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			sample_s1  <= sample;
			restart_s1 <= restart;
		end
		if (s1_go) begin
			status_s2 <= trk_status;
			mean_s2   <= trk_mean;
			value_s2  <= trk_value;
		end
		if (s2_go) begin
			status_q <= status_s2;
			level_q  <= mean_level;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign level     = level_q;

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s2 && valid_s1) |-> !in_ready)
		else $error("input taken with every stage occupied");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_load) |=> valid_s2 && $stable(value_s2))
		else $error("tracking stage lost a stalled beat");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |=> valid_s1 && $stable(sample_s1))
		else $error("input stage lost a stalled beat");

endmodule

`default_nettype wire

// File: rtl/core/ssq_track.sv
`default_nettype none

module ssq_track #(
	parameter int WINDOW_DEPTH = 6,
	localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ssq_pkg::cfg_t       cfg,
	input  wire logic signed [15:0]  sample,
	input  wire logic                restart,
	input  wire logic                advance,
	output ssq_pkg::status_t         status,
	output logic                     is_mean,
	output logic signed [SUM_W-1:0]  value
);
	import ssq_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);

	logic signed [15:0] win_q [WINDOW_DEPTH];
	logic [SLOT_W-1:0]  slot_q;
	logic [FILL_W-1:0]  fill_q;
	logic [3:0]         fault_q;
	logic [9:0]         taken_q;
	status_t            held_status_q;
	logic               held_mean_q;
	logic signed [SUM_W-1:0] held_value_q;

	logic [SLOT_W-1:0]  slot_eff, slot_new;
	logic [FILL_W-1:0]  fill_eff, fill_new;
	logic [3:0]         fault_eff, fault_new;
	logic [9:0]         taken_eff, taken_new;
	logic               held;
	logic               out_of_range;
	logic signed [15:0] win_next [WINDOW_DEPTH];
	logic signed [15:0] mn, mx;
	logic signed [SUM_W-1:0] sum;
	logic [16:0]        spread;
	status_t            status_new;
	logic               mean_new;
	logic signed [SUM_W-1:0] value_new;

	// restart clears the run before this beat's sample is used
	assign slot_eff  = restart ? '0 : slot_q;
	assign fill_eff  = restart ? '0 : fill_q;
	assign fault_eff = restart ? '0 : fault_q;
	assign taken_eff = restart ? '0 : taken_q;
	assign held      = !restart && (held_status_q != ST_WAIT);

	assign slot_new  = (slot_eff == SLOT_LAST) ? '0 : slot_eff + 1'b1;
	assign fill_new  = (fill_eff == FILL_FULL) ? FILL_FULL : fill_eff + 1'b1;
	assign taken_new = (taken_eff == TAKEN_MAX) ? TAKEN_MAX : taken_eff + 1'b1;

	assign out_of_range = (sample < $signed(cfg.range_low))
		|| (sample > $signed(cfg.range_high));
	assign fault_new = !out_of_range ? '0
		: (fault_eff == FAULT_RUN_MAX) ? FAULT_RUN_MAX : fault_eff + 1'b1;

	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			win_next[i] = (slot_eff == SLOT_W'(i)) ? sample : win_q[i];
		end
	end

	always_comb begin
		mn  = win_next[0];
		mx  = win_next[0];
		sum = {{(SUM_W-16){win_next[0][15]}}, win_next[0]};
		for (int i = 1; i < WINDOW_DEPTH; i++) begin
			if (win_next[i] < mn) begin
				mn = win_next[i];
			end
			if (win_next[i] > mx) begin
				mx = win_next[i];
			end
			sum = sum + {{(SUM_W-16){win_next[i][15]}}, win_next[i]};
		end
	end

	assign spread = {mx[15], mx} - {mn[15], mn};

	always_comb begin
		status_new = ST_WAIT;
		mean_new   = 1'b0;
		value_new  = {{(SUM_W-16){sample[15]}}, sample};
		if (fault_new >= cfg.fault_run_limit) begin
			status_new = ST_NO_PROBE;
		end else begin
			if (fill_new == FILL_FULL) begin
				mean_new  = 1'b1;
				value_new = sum;
				if (spread < {1'b0, cfg.stable_spread}) begin
					status_new = ST_STABLE;
				end
			end
			if (status_new == ST_WAIT && taken_new >= cfg.sample_limit) begin
				status_new = ST_UNSTABLE;
			end
		end
	end

	assign status  = held ? held_status_q : status_new;
	assign is_mean = held ? held_mean_q : mean_new;
	assign value   = held ? held_value_q : value_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q        <= '0;
			fill_q        <= '0;
			fault_q       <= '0;
			taken_q       <= '0;
			held_status_q <= ST_WAIT;
			held_mean_q   <= 1'b0;
		end else if (advance && !held) begin
			slot_q        <= slot_new;
			fill_q        <= fill_new;
			fault_q       <= fault_new;
			taken_q       <= taken_new;
			held_status_q <= status_new;
			held_mean_q   <= mean_new;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !held) begin
			win_q[slot_eff] <= sample;
			if (status_new != ST_WAIT) begin
				held_value_q <= value_new;
			end
		end
	end

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("window fill count past depth");

	a_held_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(held_status_q != ST_WAIT && !(advance && restart))
		|=> (held_status_q == $past(held_status_q)) && $stable(taken_q))
		else $error("held decision changed without restart");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_LAST)
		else $error("write slot out of window");

endmodule

`default_nettype wire

// File: rtl/core/ssq_mean.sv
`default_nettype none

module ssq_mean #(
	parameter int WINDOW_DEPTH = 6,
	localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH)
) (
	input  wire logic                is_mean,
	input  wire logic signed [SUM_W-1:0] value,
	output logic signed [15:0]       level
);
	// truncating divide by the depth: |sum| times a rounded-up reciprocal,
	// exact for every magnitude below 2**SUM_W
	localparam int K     = SUM_W + $clog2(WINDOW_DEPTH);
	localparam int M_W   = SUM_W + 1;
	localparam longint RECIP_L = ((64'sd1 <<< K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
	localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

	logic               neg;
	logic [SUM_W-1:0]   mag;
	logic [SUM_W+M_W-1:0] prod;
	logic [15:0]        quot;

	assign neg  = value[SUM_W-1];
	assign mag  = neg ? (~value + 1'b1) : value;
	assign prod = {{M_W{1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};
	assign quot = prod[K +: 16];

	assign level = !is_mean ? value[15:0] : (neg ? (~quot + 1'b1) : quot);

endmodule

`default_nettype wire
